@@ rtl/mvfs_pkg.sv @@
// Shared widths, event codes and fade mode codes of the music volume fade sequencer.
package mvfs_pkg;

    localparam int OP_W     = 4;
    localparam int TIME_W   = 32;
    localparam int LEN_W    = 16;
    localparam int VOL_W    = 11;
    localparam int MODE_W   = 2;
    localparam int PROD_W   = VOL_W + LEN_W;
    localparam int IN_W     = 80;
    localparam int OUT_W    = 24;

    localparam logic [OP_W-1:0] OP_TICK       = 4'd0;
    localparam logic [OP_W-1:0] OP_PLAY       = 4'd1;
    localparam logic [OP_W-1:0] OP_STOP       = 4'd2;
    localparam logic [OP_W-1:0] OP_PAUSE      = 4'd3;
    localparam logic [OP_W-1:0] OP_RESUME     = 4'd4;
    localparam logic [OP_W-1:0] OP_FADE_IN    = 4'd5;
    localparam logic [OP_W-1:0] OP_FADE_OUT   = 4'd6;
    localparam logic [OP_W-1:0] OP_OUT_IN     = 4'd7;
    localparam logic [OP_W-1:0] OP_SET_VOLUME = 4'd8;
    localparam logic [OP_W-1:0] OP_SET_ENABLE = 4'd9;

    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_IN     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OUT    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_OUT_IN = 2'd3;

    localparam logic [VOL_W-1:0] FULL_SCALE   = 11'd1024;
    localparam logic [VOL_W-1:0] RESET_VOLUME = 11'd600;

    typedef struct packed {
        logic              track_stop;
        logic              track_start;
        logic [MODE_W-1:0] fade_state;
        logic              paused;
        logic              playing;
        logic [VOL_W-1:0]  volume;
    } result_t;

endpackage

@@ rtl/music_volume_fade_sequencer.sv @@
// Top level of the music volume fade sequencer: event decoding, player state, result register.
//
// Each input beat is one event, and each accepted beat yields exactly one
// result beat that reports the volume, the playback flags, the fade mode and
// the track start and stop strobes after that event. Events that need no
// arithmetic are decoded in the cycle they are accepted, and their result is
// ready on the next cycle. A tick that falls inside a running fade computes
// saved * position / length with a bit-serial multiplier followed by a
// bit-serial restoring divider, and its result is registered once the divider
// is done. One event is in work at a time; a new beat is taken while the
// previous result is being handed over.
module music_volume_fade_sequencer
    import mvfs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // now_ms[31:0], fade_len[47:32], next_fade_len[63:48], level[74:64], enable[75]
    input  logic [IN_W-1:0]  s_tdata,
    // op[3:0]
    input  logic [OP_W-1:0]  s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // volume[10:0], playing[11], paused[12], fade_state[14:13],
    // track_start[15], track_stop[16]
    output logic [OUT_W-1:0] m_tdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]        state_reg;
    logic              playing_reg;
    logic              paused_reg;
    logic              enabled_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [TIME_W-1:0] start_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  lenq_reg;
    logic [VOL_W-1:0]  saved_reg;
    logic [VOL_W-1:0]  vol_reg;
    logic              out_valid_reg;
    result_t           out_reg;

    logic              playing_next;
    logic              paused_next;
    logic              enabled_next;
    logic [MODE_W-1:0] mode_next;
    logic [TIME_W-1:0] start_next;
    logic [LEN_W-1:0]  len_next;
    logic [LEN_W-1:0]  lenq_next;
    logic [VOL_W-1:0]  saved_next;
    logic [VOL_W-1:0]  vol_next;
    logic              fstart;
    logic              fstop;
    logic              need_div;
    logic              fi_go;
    logic [LEN_W-1:0]  fi_len;

    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] now_ms;
    logic [LEN_W-1:0]  fade_len;
    logic [LEN_W-1:0]  next_fade_len;
    logic [VOL_W-1:0]  level;
    logic              enable;

    logic [TIME_W-1:0] elapsed;
    logic              fade_over;
    logic [LEN_W-1:0]  ramp_pos;
    logic              accept;
    logic              out_load;
    logic              mul_done;
    logic [PROD_W-1:0] product;
    logic              div_done;
    logic [VOL_W-1:0]  quotient;

    assign op            = s_tuser;
    assign now_ms        = s_tdata[31:0];
    assign fade_len      = s_tdata[47:32];
    assign next_fade_len = s_tdata[63:48];
    assign level         = s_tdata[74:64];
    assign enable        = s_tdata[75];

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign out_load = ((state_reg == ST_IDLE) && accept && !need_div)
                    || ((state_reg == ST_DIV) && div_done);

    assign elapsed   = now_ms - start_reg;
    assign fade_over = elapsed >= TIME_W'(len_reg);
    assign ramp_pos  = (mode_reg == MODE_IN) ? elapsed[LEN_W-1:0]
                                             : len_reg - elapsed[LEN_W-1:0];

    always_comb
    begin
        playing_next = playing_reg;
        paused_next  = paused_reg;
        enabled_next = enabled_reg;
        mode_next    = mode_reg;
        start_next   = start_reg;
        len_next     = len_reg;
        lenq_next    = lenq_reg;
        saved_next   = saved_reg;
        vol_next     = vol_reg;
        fstart       = 1'b0;
        fstop        = 1'b0;
        need_div     = 1'b0;
        fi_go        = 1'b0;
        fi_len       = '0;

        unique case (op)
            OP_TICK:
            begin
                if (mode_reg != MODE_NONE)
                begin
                    if (!playing_reg)
                    begin
                        mode_next = MODE_NONE;
                        vol_next  = saved_reg;
                    end
                    else if (fade_over)
                    begin
                        vol_next = saved_reg;
                        unique case (mode_reg)
                            MODE_IN:
                            begin
                                mode_next = MODE_NONE;
                            end
                            MODE_OUT:
                            begin
                                playing_next = 1'b0;
                                fstop        = 1'b1;
                                mode_next    = MODE_NONE;
                            end
                            default:
                            begin
                                fi_go  = 1'b1;
                                fi_len = lenq_reg;
                            end
                        endcase
                    end
                    else
                    begin
                        need_div = 1'b1;
                    end
                end
            end
            OP_PLAY:
            begin
                fi_go = 1'b1;
            end
            OP_STOP:
            begin
                playing_next = 1'b0;
                fstop        = 1'b1;
            end
            OP_PAUSE:
            begin
                if (playing_reg)
                begin
                    paused_next  = 1'b1;
                    playing_next = 1'b0;
                end
            end
            OP_RESUME:
            begin
                if (paused_reg)
                begin
                    paused_next  = 1'b0;
                    playing_next = 1'b1;
                end
            end
            OP_FADE_IN:
            begin
                fi_go  = 1'b1;
                fi_len = fade_len;
            end
            OP_FADE_OUT:
            begin
                mode_next = MODE_NONE;
                if (playing_reg)
                begin
                    if (fade_len == '0)
                    begin
                        playing_next = 1'b0;
                        fstop        = 1'b1;
                    end
                    else
                    begin
                        mode_next  = MODE_OUT;
                        start_next = now_ms;
                        len_next   = fade_len;
                        saved_next = vol_reg;
                    end
                end
            end
            OP_OUT_IN:
            begin
                if ((fade_len == '0) || !playing_reg)
                begin
                    fi_go  = 1'b1;
                    fi_len = next_fade_len;
                end
                else
                begin
                    lenq_next  = next_fade_len;
                    mode_next  = MODE_OUT_IN;
                    start_next = now_ms;
                    len_next   = fade_len;
                    saved_next = vol_reg;
                end
            end
            OP_SET_VOLUME:
            begin
                vol_next = (level > FULL_SCALE) ? FULL_SCALE : level;
            end
            OP_SET_ENABLE:
            begin
                if (enabled_reg != enable)
                begin
                    enabled_next = enable;
                    if (enable && paused_reg)
                    begin
                        paused_next  = 1'b0;
                        playing_next = 1'b1;
                    end
                    else if (!enable && playing_reg)
                    begin
                        paused_next  = 1'b1;
                        playing_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Play, with an optional fade-in from silence up to the current volume.
        if (fi_go)
        begin
            mode_next   = MODE_NONE;
            paused_next = 1'b0;
            fstart      = 1'b1;
            if (enabled_reg)
            begin
                playing_next = 1'b1;
            end
            if (fi_len != '0)
            begin
                mode_next  = MODE_IN;
                start_next = now_ms;
                len_next   = fi_len;
                saved_next = vol_next;
                vol_next   = '0;
            end
        end
    end

    mvfs_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept && need_div),
        .mcand   (saved_reg),
        .mplier  (ramp_pos),
        .done    (mul_done),
        .product (product)
    );

    mvfs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_done),
        .dividend (product),
        .divisor  (len_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            playing_reg   <= 1'b0;
            paused_reg    <= 1'b0;
            enabled_reg   <= 1'b1;
            mode_reg      <= MODE_NONE;
            start_reg     <= '0;
            len_reg       <= '0;
            lenq_reg      <= '0;
            saved_reg     <= '0;
            vol_reg       <= RESET_VOLUME;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (need_div)
                        begin
                            state_reg <= ST_MUL;
                        end
                        else
                        begin
                            playing_reg <= playing_next;
                            paused_reg  <= paused_next;
                            enabled_reg <= enabled_next;
                            mode_reg    <= mode_next;
                            start_reg   <= start_next;
                            len_reg     <= len_next;
                            lenq_reg    <= lenq_next;
                            saved_reg   <= saved_next;
                            vol_reg     <= vol_next;
                        end
                    end
                end
                ST_MUL:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        vol_reg   <= quotient;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && accept && !need_div)
        begin
            out_reg.volume      <= vol_next;
            out_reg.playing     <= playing_next;
            out_reg.paused      <= paused_next;
            out_reg.fade_state  <= mode_next;
            out_reg.track_start <= fstart;
            out_reg.track_stop  <= fstop;
        end
        else if ((state_reg == ST_DIV) && div_done)
        begin
            out_reg.volume      <= quotient;
            out_reg.playing     <= playing_reg;
            out_reg.paused      <= paused_reg;
            out_reg.fade_state  <= mode_reg;
            out_reg.track_start <= 1'b0;
            out_reg.track_stop  <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_W - $bits(result_t))'(0), out_reg};

endmodule

@@ rtl/mvfs_mul.sv @@
// Bit-serial shift-and-add multiplier of the saved volume by the ramp position.
module mvfs_mul
    import mvfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [VOL_W-1:0]  mcand,
    input  logic [LEN_W-1:0]  mplier,
    output logic              done,
    output logic [PROD_W-1:0] product
);

    localparam int CNT_W = $clog2(LEN_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [VOL_W-1:0]  mcand_reg;
    logic [LEN_W-1:0]  mplier_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [PROD_W-1:0] acc_next;

    always_comb
    begin
        acc_next = {acc_reg[PROD_W-2:0], 1'b0};
        if (mplier_reg[LEN_W-1])
        begin
            acc_next = acc_next + PROD_W'(mcand_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(LEN_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= mcand;
            mplier_reg <= mplier;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            mplier_reg <= {mplier_reg[LEN_W-2:0], 1'b0};
            acc_reg    <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ rtl/mvfs_div.sv @@
// Bit-serial restoring divider that yields the ramped volume one quotient bit per cycle.
module mvfs_div
    import mvfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [LEN_W-1:0]  divisor,
    output logic              done,
    output logic [VOL_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(VOL_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [LEN_W-1:0] dsr_reg;
    logic [LEN_W-1:0] rem_reg;
    logic [VOL_W-1:0] quo_reg;
    logic [LEN_W:0]   trial;
    logic [LEN_W-1:0] diff;
    logic             fits;

    // The quotient is known to fit in the volume width, so the upper
    // dividend bits already form a partial remainder below the divisor.
    always_comb
    begin
        trial = {rem_reg, quo_reg[VOL_W-1]};
        diff  = trial[LEN_W-1:0] - dsr_reg;
        fits  = trial >= {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(VOL_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dsr_reg <= divisor;
            rem_reg <= dividend[PROD_W-1:VOL_W];
            quo_reg <= dividend[VOL_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff : trial[LEN_W-1:0];
            quo_reg <= {quo_reg[VOL_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
